### design/multi_server_admission_queue_assert.svh
// Assertion macros for the multi-server admission queue checker.
// Needs no other file; included by the checker alone.
`ifndef MULTI_SERVER_ADMISSION_QUEUE_ASSERT_SVH
`define MULTI_SERVER_ADMISSION_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MSAQ_ASSERT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("msaq assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MSAQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("msaq assertion failed");

`endif

### design/msaq_pkg.sv
// Shared constants, types and helpers of the multi-server admission queue.
// No dependencies; every other file of the block but the assertion header imports it.
package msaq_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int MAX_SERVERS = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int ID_W        = 16;
	localparam int TIME_W      = 32;
	localparam int BUSY_W      = 7;
	localparam int WAIT_W      = 9;
	localparam int CQ_DEPTH    = 2;
	localparam int CQ_IDX_W    = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	typedef enum logic {
		CMD_ARRIVAL  = 1'b0,
		CMD_COMPLETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SERVER_COUNT = 2'd0,
		REG_QUEUE_LIMIT  = 2'd1,
		REG_SERVICE_TIME = 2'd2
	} reg_idx_t;

	// Decision made by the front end for one accepted beat.
	typedef struct packed {
		logic              released;
		logic              started;
		logic              from_fifo;
		logic              enqueued;
		logic              dropped;
		logic [PTR_W-1:0]  ptr;
		logic [ID_W-1:0]   job_id;
		logic [TIME_W-1:0] now;
		logic [BUSY_W-1:0] busy;
		logic [WAIT_W-1:0] waiting;
	} action_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
	} fifo_entry_t;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + PTR_W'(1);
		return r;
	endfunction

endpackage

### design/msaq_if.sv
// Valid/ready channel interfaces of the multi-server admission queue.
// Depends on msaq_pkg for field widths.
interface msaq_in_if import msaq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [ID_W-1:0]   job_id;
	logic [TIME_W-1:0] now;

	modport source(output valid, command, job_id, now, input ready);
	modport sink(input valid, command, job_id, now, output ready);
endinterface

interface msaq_out_if import msaq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              released;
	logic [ID_W-1:0]   released_id;
	logic              started;
	logic [ID_W-1:0]   started_id;
	logic [TIME_W-1:0] finish_time;
	logic [TIME_W-1:0] wait_time;
	logic              enqueued;
	logic              dropped;
	logic [BUSY_W-1:0] busy_count;
	logic [WAIT_W-1:0] waiting_count;

	modport source(output valid, released, released_id, started, started_id, finish_time,
		wait_time, enqueued, dropped, busy_count, waiting_count, input ready);
	modport sink(input valid, released, released_id, started, started_id, finish_time,
		wait_time, enqueued, dropped, busy_count, waiting_count, output ready);
endinterface

### design/msaq_front.sv
// Front end: accepts beats, keeps server and FIFO bookkeeping, classifies each beat.
// Depends on msaq_pkg and msaq_in_if.
module msaq_front import msaq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	msaq_in_if.sink            in_ch,
	input  logic [BUSY_W-1:0]  server_count,
	input  logic [WAIT_W-1:0]  queue_limit,
	output logic               push_valid,
	input  logic               push_ready,
	output action_t            push_data
);

	logic [BUSY_W-1:0] busy_q, busy_n, busy_dec, servers;
	logic [WAIT_W-1:0] waiting_q, waiting_n, limit;
	logic [PTR_W-1:0]  head_q, head_n, tail_q, tail_n;
	logic              take;

	assign in_ch.ready = push_ready;
	assign take        = in_ch.valid && push_ready;
	assign push_valid  = in_ch.valid;

	assign servers  = (server_count > BUSY_W'(MAX_SERVERS)) ? BUSY_W'(MAX_SERVERS) : server_count;
	assign limit    = (queue_limit > WAIT_W'(QUEUE_DEPTH)) ? WAIT_W'(QUEUE_DEPTH) : queue_limit;
	assign busy_dec = (busy_q != '0) ? busy_q - BUSY_W'(1) : busy_q;

	always_comb begin
		busy_n    = busy_q;
		waiting_n = waiting_q;
		head_n    = head_q;
		tail_n    = tail_q;
		push_data = '0;
		push_data.job_id = in_ch.job_id;
		push_data.now    = in_ch.now;
		if (in_ch.command == CMD_COMPLETE) begin
			push_data.released = 1'b1;
			if (waiting_q != '0) begin
				// Head of the FIFO takes the freed server.
				push_data.started   = 1'b1;
				push_data.from_fifo = 1'b1;
				push_data.ptr       = head_q;
				head_n    = next_slot(head_q);
				waiting_n = waiting_q - WAIT_W'(1);
				busy_n    = busy_dec + BUSY_W'(1);
			end else begin
				busy_n = busy_dec;
			end
		end else begin
			priority if (busy_q < servers) begin
				push_data.started = 1'b1;
				busy_n = busy_q + BUSY_W'(1);
			end else if (waiting_q >= limit) begin
				push_data.dropped = 1'b1;
			end else begin
				push_data.enqueued = 1'b1;
				push_data.ptr      = tail_q;
				tail_n    = next_slot(tail_q);
				waiting_n = waiting_q + WAIT_W'(1);
			end
		end
		push_data.busy    = busy_n;
		push_data.waiting = waiting_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			waiting_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
		end else if (take) begin
			busy_q    <= busy_n;
			waiting_q <= waiting_n;
			head_q    <= head_n;
			tail_q    <= tail_n;
		end
	end

endmodule

### design/msaq_cq.sv
// Short decision queue between front and back end.
// Depends on msaq_pkg.
module msaq_cq import msaq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  action_t push_data,
	output logic    pop_valid,
	input  logic    pop_ready,
	output action_t pop_data
);

	action_t             ent_q [CQ_DEPTH];
	logic [CQ_IDX_W-1:0] wr_q, rd_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                push, pop;

	assign push_ready = cnt_q != CQ_CNT_W'(CQ_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = ent_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [CQ_IDX_W-1:0] bump(input logic [CQ_IDX_W-1:0] p);
		logic [CQ_IDX_W-1:0] r;
		if (p == CQ_IDX_W'(CQ_DEPTH - 1))
			r = '0;
		else
			r = p + CQ_IDX_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= bump(wr_q);
			if (pop)
				rd_q <= bump(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + CQ_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CQ_CNT_W'(1);
		end
	end

endmodule

### design/msaq_back.sv
// Back end: owns the waiting-job memory, forms result beats in an output register.
// Depends on msaq_pkg and msaq_out_if.
module msaq_back import msaq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  action_t            pop_data,
	input  logic [TIME_W-1:0]  service_time,
	msaq_out_if.source         out_ch
);

	fifo_entry_t       mem [QUEUE_DEPTH];
	fifo_entry_t       rd_s1;
	action_t           act_s1;
	logic              valid_s1_q;
	logic              pop, adv;

	logic              out_valid_q;
	logic              released_q, started_q, enqueued_q, dropped_q;
	logic [ID_W-1:0]   released_id_q, started_id_q;
	logic [TIME_W-1:0] finish_q, wait_q;
	logic [BUSY_W-1:0] busy_q;
	logic [WAIT_W-1:0] waiting_q;

	assign adv       = valid_s1_q && (!out_valid_q || out_ch.ready);
	assign pop_ready = !valid_s1_q || adv;
	assign pop       = pop_valid && pop_ready;

	// Memory: write on enqueue, registered read on a start from the FIFO.
	always_ff @(posedge clk) begin
		if (pop && pop_data.enqueued)
			mem[pop_data.ptr] <= '{id: pop_data.job_id, stamp: pop_data.now};
		if (pop && pop_data.from_fifo)
			rd_s1 <= mem[pop_data.ptr];
		if (pop)
			act_s1 <= pop_data;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			released_q    <= act_s1.released;
			released_id_q <= act_s1.released ? act_s1.job_id : '0;
			started_q     <= act_s1.started;
			priority if (act_s1.from_fifo)
				started_id_q <= rd_s1.id;
			else if (act_s1.started)
				started_id_q <= act_s1.job_id;
			else
				started_id_q <= '0;
			finish_q   <= act_s1.started ? act_s1.now + service_time : '0;
			wait_q     <= act_s1.from_fifo ? act_s1.now - rd_s1.stamp : '0;
			enqueued_q <= act_s1.enqueued;
			dropped_q  <= act_s1.dropped;
			busy_q     <= act_s1.busy;
			waiting_q  <= act_s1.waiting;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				valid_s1_q <= 1'b1;
			else if (adv)
				valid_s1_q <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.released      = released_q;
	assign out_ch.released_id   = released_id_q;
	assign out_ch.started       = started_q;
	assign out_ch.started_id    = started_id_q;
	assign out_ch.finish_time   = finish_q;
	assign out_ch.wait_time     = wait_q;
	assign out_ch.enqueued      = enqueued_q;
	assign out_ch.dropped       = dropped_q;
	assign out_ch.busy_count    = busy_q;
	assign out_ch.waiting_count = waiting_q;

endmodule

### design/multi_server_admission_queue.sv
// Top level of the multi-server admission queue: register port, front, queue, back.
// Depends on msaq_pkg, msaq_if, msaq_front, msaq_cq and msaq_back.
//
//   channel  | direction | handshake         | beat
//   ---------+-----------+-------------------+------------------------------------
//   in_ch    | in        | valid/ready       | command, job_id, now
//   out_ch   | out       | valid/ready       | released.., started.., counts
//   apb      | in        | psel/penable, rdy | server_count, queue_limit, service_time
//
// One beat is accepted per cycle while in_ch.ready is high; results leave the output register.
// The front end decides each beat in the accept cycle from its counters; the 2-entry
// queue and the back end's one stage plus output register hold decided beats.
// A stalled output fills the queue and then drops in_ch.ready.
// Reset clears counters, pointers and valids; the job memory is not cleared.
module multi_server_admission_queue import msaq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	msaq_in_if.sink               in_ch,
	msaq_out_if.source            out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [BUSY_W-1:0] server_count_q;
	logic [WAIT_W-1:0] queue_limit_q;
	logic [TIME_W-1:0] service_time_q;
	logic              cfg_wr;
	reg_idx_t          reg_idx;

	logic    push_valid, push_ready, pop_valid, pop_ready;
	action_t push_data, pop_data;

	// Register port: no wait states; write on the access phase.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= BUSY_W'(1);
			queue_limit_q  <= WAIT_W'(QUEUE_DEPTH);
			service_time_q <= TIME_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SERVER_COUNT: server_count_q <= pwdata[BUSY_W-1:0];
				REG_QUEUE_LIMIT:  queue_limit_q  <= pwdata[WAIT_W-1:0];
				REG_SERVICE_TIME: service_time_q <= pwdata[TIME_W-1:0];
				default: ;  // drop writes outside the register list
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SERVER_COUNT: prdata = APB_DATA_W'(server_count_q);
			REG_QUEUE_LIMIT:  prdata = APB_DATA_W'(queue_limit_q);
			REG_SERVICE_TIME: prdata = APB_DATA_W'(service_time_q);
			default:          prdata = '0;
		endcase
	end

	// Classify each arrival or completion and advance the bookkeeping.
	msaq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.server_count (server_count_q),
		.queue_limit  (queue_limit_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	// Hold decided beats so each side can stall on its own.
	msaq_cq u_cq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Store and fetch waiting jobs, compute times, present result beats.
	msaq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.service_time (service_time_q),
		.out_ch       (out_ch)
	);

endmodule

### design/msaq_checker.sv
// Port-level checker of the multi-server admission queue, bound to the top level.
// Depends on msaq_pkg and multi_server_admission_queue_assert.svh.
`include "multi_server_admission_queue_assert.svh"

module msaq_checker import msaq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              out_released,
	input logic              out_started,
	input logic              out_enqueued,
	input logic              out_dropped,
	input logic [TIME_W-1:0] out_wait_time,
	input logic [BUSY_W-1:0] out_busy_count,
	input logic [WAIT_W-1:0] out_waiting_count
);

	`MSAQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_busy_count))
	`MSAQ_ASSERT(a_drop_alone, clk, arst_n, out_valid && out_dropped, !out_started && !out_enqueued && !out_released)
	`MSAQ_ASSERT(a_enq_counts, clk, arst_n, out_valid && out_enqueued, out_waiting_count != '0)
	`MSAQ_ASSERT(a_direct_start, clk, arst_n, out_valid && out_started && !out_released, out_wait_time == '0 && out_busy_count != '0)

endmodule

bind multi_server_admission_queue msaq_checker u_msaq_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.out_released      (out_ch.released),
	.out_started       (out_ch.started),
	.out_enqueued      (out_ch.enqueued),
	.out_dropped       (out_ch.dropped),
	.out_wait_time     (out_ch.wait_time),
	.out_busy_count    (out_ch.busy_count),
	.out_waiting_count (out_ch.waiting_count)
);
